@@ design/ekc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the exactly-k cardinality propagator.
// Depends on nothing; every other file of the block imports it.
package ekc_pkg;

  localparam int OP_W       = 2;
  localparam int VAR_W      = 6;
  localparam int TGT_W      = 5;
  localparam int LVL_W      = 6;
  localparam int VCNT_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [OP_W-1:0] {
    OP_ASSIGN    = 2'd0,
    OP_NEW_LEVEL = 2'd1,
    OP_BACKTRACK = 2'd2
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_VAR_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K_TARGET  = 1'd1;

  // Broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic              asg_en;
    logic [VAR_W-1:0]  asg_idx;
    logic              asg_val;
    logic              bt_en;
    logic [LVL_W-1:0]  bt_target;
    logic [LVL_W-1:0]  level;
    logic [VCNT_W-1:0] n_eff;
    logic              adv;
    logic              emit;
  } cell_cmd_t;

endpackage

@@ design/ekc_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input beats and the result beats.
// Depends on ekc_pkg for the field widths.
interface ekc_in_if;
  import ekc_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [VAR_W-1:0] var_index;
  logic             var_value;
  logic             batch_end;
  logic [TGT_W-1:0] target_level;

  modport source (output valid, opcode, var_index, var_value, batch_end, target_level,
                  input ready);
  modport sink (input valid, opcode, var_index, var_value, batch_end, target_level,
                output ready);
endinterface

interface ekc_out_if;
  import ekc_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAR_W-1:0] implied_var;
  logic             implied_value;
  logic             last;

  modport source (output valid, implied_var, implied_value, last, input ready);
  modport sink (input valid, implied_var, implied_value, last, output ready);
endinterface

@@ design/ekc_cell.sv @@
`timescale 1ns / 1ps
// One variable of the propagator: assignment and implication marks with their levels,
// plus one stage of the scan token and of the running true/false counts.
// Depends on ekc_pkg.
module ekc_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ekc_pkg::cell_cmd_t  cmd,
  input  logic                tok_in,
  input  logic [CNT_W-1:0]    cnt_t_in,
  input  logic [CNT_W-1:0]    cnt_f_in,
  output logic                tok_out,
  output logic [CNT_W-1:0]    cnt_t_out,
  output logic [CNT_W-1:0]    cnt_f_out,
  output logic                hit
);
  import ekc_pkg::*;

  localparam logic [VCNT_W-1:0] MY_POS = VCNT_W'(IDX);
  localparam logic [VCNT_W-1:0] MY_NUM = VCNT_W'(IDX + 1);

  logic             t_r, f_r, imp_r, tok_r;
  logic [LVL_W-1:0] alvl_r, ilvl_r;
  logic [CNT_W-1:0] cnt_t_r, cnt_f_r;
  logic             active, sel, elig;

  assign active = (cmd.n_eff > MY_POS);
  assign sel    = cmd.asg_en && ({1'b0, cmd.asg_idx} == MY_NUM) && active;
  assign elig   = active && !t_r && !f_r && !imp_r;
  assign hit    = tok_r && cmd.emit && elig;

  assign tok_out   = tok_r;
  assign cnt_t_out = cnt_t_r + CNT_W'(active && t_r);
  assign cnt_f_out = cnt_f_r + CNT_W'(active && f_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r   <= 1'b0;
      f_r   <= 1'b0;
      imp_r <= 1'b0;
      tok_r <= 1'b0;
    end else begin
      if (sel) begin
        t_r <= cmd.asg_val;
        f_r <= !cmd.asg_val;
      end else if (cmd.bt_en && (t_r || f_r) && (alvl_r > cmd.bt_target)) begin
        t_r <= 1'b0;
        f_r <= 1'b0;
      end
      if (hit && cmd.adv) begin
        imp_r <= 1'b1;
      end else if (cmd.bt_en && imp_r && (ilvl_r > cmd.bt_target)) begin
        imp_r <= 1'b0;
      end
      if (cmd.adv) begin
        tok_r <= tok_in;
      end
    end
  end

  // Levels and counts are only looked at where a mask bit or the token says so.
  always_ff @(posedge clk) begin
    if (sel) begin
      alvl_r <= cmd.level;
    end
    if (hit && cmd.adv) begin
      ilvl_r <= cmd.level;
    end
    if (cmd.adv) begin
      cnt_t_r <= cnt_t_in;
      cnt_f_r <= cnt_f_in;
    end
  end

endmodule

@@ design/ekc_seq.sv @@
`timescale 1ns / 1ps
// Sequencer of the propagator: configuration registers, decision level, scan passes
// over the cell chain, pending result and output register. Depends on ekc_pkg, ekc_if.
module ekc_seq #(
  parameter int MAX_VARS   = 32,
  parameter int MAX_LEVELS = 32,
  parameter int CNT_W      = 6
) (
  input  logic                               clk,
  input  logic                               rst_n,
  ekc_in_if.sink                             in_ch,
  ekc_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [ekc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ekc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ekc_pkg::cell_cmd_t                 cmd,
  output logic                               tok_head,
  input  logic [MAX_VARS-1:0]                hits,
  input  logic                               tok_last,
  input  logic [CNT_W-1:0]                   cnt_t_last,
  input  logic [CNT_W-1:0]                   cnt_f_last
);
  import ekc_pkg::*;

  localparam int IW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam logic [IW-1:0]     LAST_IDX  = IW'(MAX_VARS - 1);
  localparam logic [LVL_W-1:0]  TOP_LEVEL = LVL_W'(MAX_LEVELS - 1);
  localparam logic [VCNT_W-1:0] VARS_CAP  = VCNT_W'(MAX_VARS);

  typedef enum logic [2:0] {S_IDLE, S_COUNT, S_RULE0, S_RULE1, S_FLUSH} state_t;

  state_t                state_r, state_nxt;
  logic [CFG_DATA_W-1:0] var_count_r, var_count_nxt;
  logic [CFG_DATA_W-1:0] k_r, k_nxt;
  logic [LVL_W-1:0]      level_r, level_nxt;
  logic                  fire1_r, fire1_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [VAR_W-1:0]      pend_var_r, pend_var_nxt;
  logic                  pend_val_r, pend_val_nxt;
  logic                  out_v_r, out_v_nxt;
  logic [VAR_W-1:0]      out_var_r, out_var_nxt;
  logic                  out_val_r, out_val_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  accept, out_free, hit_any, adv, scan_end, bt_en;
  logic                  fire0_now, fire1_now, rule_val;
  logic [VCNT_W-1:0]     n_eff, k_ext, trues_ext, falses_ext;
  logic [LVL_W-1:0]      target_ext;

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free   = !out_v_r || out_ch.ready;
  assign hit_any    = |hits;
  assign n_eff      = (VCNT_W'(var_count_r) < VARS_CAP) ? VCNT_W'(var_count_r) : VARS_CAP;
  assign k_ext      = VCNT_W'(k_r);
  assign trues_ext  = VCNT_W'(cnt_t_last);
  assign falses_ext = VCNT_W'(cnt_f_last);
  assign target_ext = LVL_W'(in_ch.target_level);
  assign fire0_now  = (trues_ext == k_ext);
  assign fire1_now  = (k_ext <= n_eff) && (falses_ext == (n_eff - k_ext));
  assign rule_val   = (state_r == S_RULE1);
  assign bt_en      = accept && (opcode_t'(in_ch.opcode) == OP_BACKTRACK) &&
                      (target_ext < level_r);

  // A rule pass stalls only when a new hit finds both the pending slot and the
  // output register occupied.
  always_comb begin
    case (state_r)
      S_RULE0, S_RULE1: adv = !hit_any || !pend_v_r || out_free;
      default:          adv = 1'b1;
    endcase
  end

  assign scan_end = adv && (idx_r == LAST_IDX);

  assign cmd.asg_en    = accept && (opcode_t'(in_ch.opcode) == OP_ASSIGN);
  assign cmd.asg_idx   = in_ch.var_index;
  assign cmd.asg_val   = in_ch.var_value;
  assign cmd.bt_en     = bt_en;
  assign cmd.bt_target = target_ext;
  assign cmd.level     = level_r;
  assign cmd.n_eff     = n_eff;
  assign cmd.adv       = adv;
  assign cmd.emit      = (state_r == S_RULE0) || (state_r == S_RULE1);

  assign out_ch.valid         = out_v_r;
  assign out_ch.implied_var   = out_var_r;
  assign out_ch.implied_value = out_val_r;
  assign out_ch.last          = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    var_count_nxt = var_count_r;
    k_nxt         = k_r;
    level_nxt     = level_r;
    fire1_nxt     = fire1_r;
    idx_nxt       = idx_r;
    pend_v_nxt    = pend_v_r;
    pend_var_nxt  = pend_var_r;
    pend_val_nxt  = pend_val_r;
    out_v_nxt     = out_v_r && !out_ch.ready;
    out_var_nxt   = out_var_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    tok_head      = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_VAR_COUNT: var_count_nxt = cfg_data;
        CFG_K_TARGET:  k_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode_t'(in_ch.opcode))
            OP_ASSIGN: begin
              if (in_ch.batch_end) begin
                tok_head  = 1'b1;
                state_nxt = S_COUNT;
              end
            end
            OP_NEW_LEVEL: begin
              if (level_r < TOP_LEVEL) begin
                level_nxt = level_r + LVL_W'(1);
              end
            end
            OP_BACKTRACK: begin
              if (bt_en) begin
                level_nxt = target_ext;
              end
            end
            default: ;
          endcase
        end
      end
      S_COUNT: begin
        if (tok_last) begin
          fire1_nxt = fire1_now;
          idx_nxt   = '0;
          if (fire0_now) begin
            tok_head  = 1'b1;
            state_nxt = S_RULE0;
          end else if (fire1_now) begin
            tok_head  = 1'b1;
            state_nxt = S_RULE1;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_RULE0, S_RULE1: begin
        if (adv) begin
          idx_nxt = idx_r + IW'(1);
          if (hit_any) begin
            if (pend_v_r) begin
              out_v_nxt    = 1'b1;
              out_var_nxt  = pend_var_r;
              out_val_nxt  = pend_val_r;
              out_last_nxt = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_var_nxt = VAR_W'(idx_r) + VAR_W'(1);
            pend_val_nxt = rule_val;
          end
          if (scan_end) begin
            idx_nxt = '0;
            if ((state_r == S_RULE0) && fire1_r) begin
              tok_head  = 1'b1;
              state_nxt = S_RULE1;
            end else begin
              state_nxt = S_FLUSH;
            end
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_var_nxt  = pend_var_r;
          out_val_nxt  = pend_val_r;
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      var_count_r <= CFG_DATA_W'(32);
      k_r         <= '0;
      level_r     <= '0;
      fire1_r     <= 1'b0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      var_count_r <= var_count_nxt;
      k_r         <= k_nxt;
      level_r     <= level_nxt;
      fire1_r     <= fire1_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      out_v_r     <= out_v_nxt;
    end
    pend_var_r <= pend_var_nxt;
    pend_val_r <= pend_val_nxt;
    out_var_r  <= out_var_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

@@ design/exactly_k_cardinality_propagator_core.sv @@
`timescale 1ns / 1ps
// Exactly-k cardinality propagator: keeps a SAT assignment trail split by decision
// level and emits the literals forced by an exactly-k constraint over variables 1..n.
// Input beats on in_ch carry an opcode: assign a variable, open a new decision level,
// or backtrack to a target level. Result beats on out_ch carry one implied literal
// each; last marks the final implication caused by one input beat.
// Configuration (var_count, k_target) is written through cfg_we / cfg_index /
// cfg_data; the user must do so only while the block is idle, as the block itself does no check.
// An assign without batch end, a new level and a backtrack leave the block idle.
// An assign with batch end runs up to three passes of a token along the chain of
// MAX_VARS cells: one pass adds up the true and false counts, then one pass for
// each rule that fires, moving one cell per cycle unless the output stalls and
// emitting at most one implication per cycle; the final beat is then released.
// in_ch.ready is high only while no batch is being processed.
// When the receiver stalls, one implication waits in the output register and one
// in a pending slot; the token then stops until the output register frees up.
// Reset (synchronous, active low) clears all marks, the level and the pipeline,
// and loads var_count = 32, k_target = 0.
module exactly_k_cardinality_propagator_core #(
  parameter int MAX_VARS   = 32,
  parameter int MAX_LEVELS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  ekc_in_if.sink                             in_ch,
  ekc_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [ekc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ekc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ekc_pkg::*;

  // Counts run up to MAX_VARS, so they need one more code than the chain length.
  localparam int CNT_W = $clog2(MAX_VARS + 1);

  cell_cmd_t        cmd;
  logic             tok_head;
  logic [MAX_VARS-1:0] hits;
  logic             tok_chain [MAX_VARS+1];
  logic [CNT_W-1:0] cnt_t_chain [MAX_VARS+1];
  logic [CNT_W-1:0] cnt_f_chain [MAX_VARS+1];

  // The head of the chain takes the token from the sequencer with empty counts.
  assign tok_chain[0]   = tok_head;
  assign cnt_t_chain[0] = '0;
  assign cnt_f_chain[0] = '0;

  ekc_seq #(
    .MAX_VARS   (MAX_VARS),
    .MAX_LEVELS (MAX_LEVELS),
    .CNT_W      (CNT_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .tok_head   (tok_head),
    .hits       (hits),
    .tok_last   (tok_chain[MAX_VARS]),
    .cnt_t_last (cnt_t_chain[MAX_VARS]),
    .cnt_f_last (cnt_f_chain[MAX_VARS])
  );

  // Cell i holds variable i+1; each hands the token and the running counts to the next.
  for (genvar i = 0; i < MAX_VARS; i++) begin : g_cell
    ekc_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .tok_in    (tok_chain[i]),
      .cnt_t_in  (cnt_t_chain[i]),
      .cnt_f_in  (cnt_f_chain[i]),
      .tok_out   (tok_chain[i+1]),
      .cnt_t_out (cnt_t_chain[i+1]),
      .cnt_f_out (cnt_f_chain[i+1]),
      .hit       (hits[i])
    );
  end

endmodule
